// File: rtl/sspr_pkg.sv
// ---------------------------------------------------------------------------
// sspr_pkg
// shared types and codes of the servo status packet receiver
// ---------------------------------------------------------------------------
package sspr_pkg;

   // request kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_TICK  = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;

   // result kinds
   localparam logic RESULT_PAYLOAD = 1'b0;
   localparam logic RESULT_STATUS  = 1'b1;

   // final status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_TIMEOUT  = 3'd1;
   localparam logic [2:0] ST_ID       = 3'd2;
   localparam logic [2:0] ST_LENGTH   = 3'd3;
   localparam logic [2:0] ST_SERVO    = 3'd4;
   localparam logic [2:0] ST_CHECKSUM = 3'd5;

   // csr indexes
   localparam logic [1:0] CSR_EXPECTED_ID     = 2'd0;
   localparam logic [1:0] CSR_PAYLOAD_LENGTH  = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_TICKS   = 2'd2;

   localparam logic [7:0]  SYNC_BYTE           = 8'hFF;
   localparam logic [7:0]  RESET_EXPECTED_ID   = 8'd1;
   localparam logic [7:0]  RESET_PAYLOAD_LEN   = 8'd0;
   localparam logic [15:0] RESET_TIMEOUT_TICKS = 16'd100;
   localparam logic [15:0] TICKS_MAX           = 16'hFFFF;

   typedef struct packed {
      logic [7:0]  expected_id;
      logic [7:0]  expected_payload_length;
      logic [15:0] timeout_ticks;
   } sspr_config_type;

   typedef struct packed {
      logic       valid;
      logic       result_kind;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic [2:0] status;
      logic       is_last;
   } sspr_result_type;

endpackage

// File: rtl/sspr_parser.sv
// ---------------------------------------------------------------------------
// sspr_parser
// packet parser state and per-transaction decode
// ---------------------------------------------------------------------------
module sspr_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [1:0]                kind,
   input  logic [7:0]                rx_byte,
   input  sspr_pkg::sspr_config_type cfg,
   output sspr_pkg::sspr_result_type result
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_HUNT, PH_ID, PH_LEN, PH_ERR, PH_PAY, PH_SUM
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        prev_was_ff_ff, prev_was_ff_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] ticks_ff, ticks_in;

   logic [15:0] ticks_next;
   logic [7:0]  count_next;
   logic [8:0]  length_needed;
   logic        is_sync;

   assign ticks_next    = (ticks_ff != sspr_pkg::TICKS_MAX) ? ticks_ff + 16'd1 : ticks_ff;
   assign count_next    = count_ff + 8'd1;
   assign length_needed = {1'b0, cfg.expected_payload_length} + 9'd2;
   assign is_sync       = (rx_byte == sspr_pkg::SYNC_BYTE);

   always_comb begin
      phase_in       = phase_ff;
      prev_was_ff_in = prev_was_ff_ff;
      sum_in         = sum_ff;
      count_in       = count_ff;
      ticks_in       = ticks_ff;
      result         = '0;

      if (kind == sspr_pkg::KIND_START) begin
         phase_in       = PH_HUNT;
         prev_was_ff_in = 1'b0;
         sum_in         = '0;
         count_in       = '0;
         ticks_in       = '0;
         if (cfg.timeout_ticks == '0) begin
            phase_in       = PH_IDLE;
            result.valid       = 1'b1;
            result.result_kind = sspr_pkg::RESULT_STATUS;
            result.status      = sspr_pkg::ST_TIMEOUT;
            result.is_last     = 1'b1;
         end
      end else if (phase_ff != PH_IDLE && kind == sspr_pkg::KIND_TICK) begin
         ticks_in = ticks_next;
         if (ticks_next >= cfg.timeout_ticks) begin
            phase_in           = PH_IDLE;
            result.valid       = 1'b1;
            result.result_kind = sspr_pkg::RESULT_STATUS;
            result.status      = sspr_pkg::ST_TIMEOUT;
            result.is_last     = 1'b1;
         end
      end else if (phase_ff != PH_IDLE && kind == sspr_pkg::KIND_BYTE) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (prev_was_ff_ff && is_sync) begin
                  phase_in = PH_ID;
               end else begin
                  prev_was_ff_in = is_sync;
               end
            end
            PH_ID: begin
               if (rx_byte != cfg.expected_id) begin
                  phase_in      = PH_IDLE;
                  result.valid  = 1'b1;
                  result.status = sspr_pkg::ST_ID;
               end else begin
                  sum_in   = rx_byte;
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if ({1'b0, rx_byte} != length_needed) begin
                  phase_in      = PH_IDLE;
                  result.valid  = 1'b1;
                  result.status = sspr_pkg::ST_LENGTH;
               end else begin
                  sum_in   = sum_ff + rx_byte;
                  phase_in = PH_ERR;
               end
            end
            PH_ERR: begin
               if (rx_byte != '0) begin
                  phase_in      = PH_IDLE;
                  result.valid  = 1'b1;
                  result.status = sspr_pkg::ST_SERVO;
               end else begin
                  phase_in = (cfg.expected_payload_length == '0) ? PH_SUM : PH_PAY;
               end
            end
            PH_PAY: begin
               result.valid         = 1'b1;
               result.result_kind   = sspr_pkg::RESULT_PAYLOAD;
               result.payload_byte  = rx_byte;
               result.payload_index = count_ff;
               sum_in   = sum_ff + rx_byte;
               count_in = count_next;
               if (count_next >= cfg.expected_payload_length) begin
                  phase_in = PH_SUM;
               end
            end
            PH_SUM: begin
               phase_in      = PH_IDLE;
               result.valid  = 1'b1;
               result.status = (rx_byte == ~sum_ff) ? sspr_pkg::ST_OK
                                                     : sspr_pkg::ST_CHECKSUM;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
         // every failure or checksum verdict is a final status
         if (result.valid && phase_ff != PH_PAY) begin
            result.result_kind = sspr_pkg::RESULT_STATUS;
            result.is_last     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         prev_was_ff_ff <= 1'b0;
         sum_ff         <= '0;
         count_ff       <= '0;
         ticks_ff       <= '0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         prev_was_ff_ff <= prev_was_ff_in;
         sum_ff         <= sum_in;
         count_ff       <= count_in;
         ticks_ff       <= ticks_in;
      end
   end

endmodule

// File: rtl/servo_status_packet_receiver.sv
// ---------------------------------------------------------------------------
// servo_status_packet_receiver
// receives a servo-bus status packet byte by byte, streams its payload
// and ends each transfer with one status transaction
// ---------------------------------------------------------------------------
//
//   channel | ports                         | direction
//   --------+-------------------------------+-----------
//   req     | req_valid/req_stall, kind,    | in
//           | rx_byte                       |
//   rsp     | rsp_valid/rsp_stall, kind,    | out
//           | byte, index, status, is_last  |
//   csr     | csr_write_enable/index/data   | in
//
// one transaction per cycle sustained while the response is not stalled;
// a request is held in the input register and its result appears in the
// response register the cycle after it is decoded by the parser
// reset is synchronous and active high; it restores the csr defaults and
// leaves the parser idle, waiting for a start transaction
// a stalled response holds the parser; an empty input register still takes
// one more request, then req_stall rises until the response is taken
// ---------------------------------------------------------------------------
module servo_status_packet_receiver (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_payload_index,
   output logic [2:0]  rsp_status,
   output logic        rsp_is_last,

   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   // configuration registers
   sspr_pkg::sspr_config_type cfg_ff;

   // input register
   logic       in_valid_ff;
   logic [1:0] in_kind_ff;
   logic [7:0] in_byte_ff;

   // response register
   logic       out_valid_ff;
   logic       out_kind_ff;
   logic [7:0] out_byte_ff;
   logic [7:0] out_index_ff;
   logic [2:0] out_status_ff;
   logic       out_last_ff;

   sspr_pkg::sspr_result_type result;
   logic out_free;
   logic advance;

   // the response register can take a new result when empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   // the held request is decoded once the result has somewhere to go
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_id             <= sspr_pkg::RESET_EXPECTED_ID;
         cfg_ff.expected_payload_length <= sspr_pkg::RESET_PAYLOAD_LEN;
         cfg_ff.timeout_ticks           <= sspr_pkg::RESET_TIMEOUT_TICKS;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sspr_pkg::CSR_EXPECTED_ID:
               cfg_ff.expected_id <= csr_write_data[7:0];
            sspr_pkg::CSR_PAYLOAD_LENGTH:
               cfg_ff.expected_payload_length <= csr_write_data[7:0];
            sspr_pkg::CSR_TIMEOUT_TICKS:
               cfg_ff.timeout_ticks <= csr_write_data;
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // input register: refills whenever it is not held back
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_kind_ff <= req_kind;
         in_byte_ff <= req_rx_byte;
      end
   end

   sspr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .kind    (in_kind_ff),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   // response register: loaded only by requests that produce a result
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         out_kind_ff   <= result.result_kind;
         out_byte_ff   <= result.payload_byte;
         out_index_ff  <= result.payload_index;
         out_status_ff <= result.status;
         out_last_ff   <= result.is_last;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_result_kind   = out_kind_ff;
   assign rsp_payload_byte  = out_byte_ff;
   assign rsp_payload_index = out_index_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_is_last       = out_last_ff;

   // a final status always closes the transfer
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == sspr_pkg::RESULT_STATUS) |-> out_last_ff)
      else $error("status transaction without is_last");

   // payload transactions carry no status and never end the transfer
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == sspr_pkg::RESULT_PAYLOAD)
         |-> (out_status_ff == sspr_pkg::ST_OK && !out_last_ff))
      else $error("payload transaction with status or is_last");

   // a held response is never overwritten by the parser
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !advance)
      else $error("parser advanced over a stalled response");

endmodule
